@@ src/half_step_stepper_sequencer_unit_defines.svh @@
// ----------------------------------------------------------------------------
// half step stepper sequencer - assertion macros
// shared assertion forms for the sequencer checker
// ----------------------------------------------------------------------------
`ifndef HALF_STEP_STEPPER_SEQUENCER_UNIT_DEFINES_SVH
`define HALF_STEP_STEPPER_SEQUENCER_UNIT_DEFINES_SVH

// property checked only outside reset
`define HSS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hss assertion failed");

// property checked on every edge, reset included
`define HSS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("hss assertion failed");

`endif

@@ src/hss_pkg.sv @@
// ----------------------------------------------------------------------------
// hss_pkg
// types, constants and the half-step coil table for the stepper sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hss_pkg;

    localparam int HSS_DELAY_WIDTH = 24;
    localparam int HSS_CFG_WIDTH   = 24;
    localparam int HSS_POS_WIDTH   = 16;
    localparam int HSS_COIL_WIDTH  = 4;

    localparam logic [HSS_CFG_WIDTH-1:0] HSS_DELAY_RESET = 24'd117;
    localparam logic [HSS_POS_WIDTH-1:0] HSS_SPT_RESET   = 16'd8;

    typedef enum logic {
        REG_STEP_DELAY     = 1'b0,
        REG_STEPS_PER_TURN = 1'b1
    } t_reg_index;

    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_MOVE = 1'b1;

    typedef logic [HSS_POS_WIDTH-1:0]  t_pos;
    typedef logic [HSS_COIL_WIDTH-1:0] t_coil;

    function automatic t_coil hss_coil_lookup(input logic [2:0] phase);
        t_coil coil;
        case (phase)
            3'd0: coil = 4'h1;
            3'd1: coil = 4'h3;
            3'd2: coil = 4'h2;
            3'd3: coil = 4'h6;
            3'd4: coil = 4'h4;
            3'd5: coil = 4'hC;
            3'd6: coil = 4'h8;
            3'd7: coil = 4'h9;
            default: coil = 4'h0;
        endcase
        return coil;
    endfunction

endpackage

@@ src/half_step_stepper_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// half_step_stepper_sequencer_unit
// four-wire half-step stepper sequencer: move requests and time ticks in,
// one coil/position/status result out per request
// ----------------------------------------------------------------------------
// A mode 1 request loads the remaining step count with the magnitude of
// i_move_steps (the sign sets direction, zero cancels the move and keeps the
// direction); a mode 0 request is one time tick that may take one step once
// step_delay_ticks ticks have passed. Every request gives exactly one result.
// The block takes one request per clock while the output side does not stall;
// a request passes from the input register through the update logic into the
// result register, which loads only while the output side can take a result.
// The step counters, elapsed-time counter and coil state all update in that
// single update stage. Configuration (index 0: step delay in ticks, index 1:
// steps per turn) is written on i_cfg_we and must only change while no request
// is in flight.
`timescale 1ns / 1ps

module half_step_stepper_sequencer_unit
    import hss_pkg::*;
#(
    parameter int DELAY_WIDTH = HSS_DELAY_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_mode,
    input  logic signed [15:0]       i_move_steps,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [3:0]               o_coil_pattern,
    output logic [15:0]              o_position,
    output logic [15:0]              o_remaining,
    output logic                     o_stepped,
    output logic                     o_busy_res,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_index,
    input  logic [HSS_CFG_WIDTH-1:0] i_cfg_data
);

    localparam int CMP_WIDTH = (DELAY_WIDTH > HSS_CFG_WIDTH) ? DELAY_WIDTH : HSS_CFG_WIDTH;

    logic [HSS_CFG_WIDTH-1:0] r_step_delay;
    t_pos                     r_steps_per_turn;

    logic                     r_in_vld;
    logic                     r_in_mode;
    logic signed [15:0]       r_in_move;

    t_pos                     r_position;
    t_pos                     r_remaining;
    logic                     r_forward;
    logic [DELAY_WIDTH-1:0]   r_elapsed;
    t_coil                    r_coil;

    t_pos                     n_position;
    t_pos                     n_remaining;
    logic                     n_forward;
    logic [DELAY_WIDTH-1:0]   n_elapsed;
    t_coil                    n_coil;
    logic                     n_stepped;

    logic                     r_out_vld;
    t_coil                    r_out_coil;
    t_pos                     r_out_position;
    t_pos                     r_out_remaining;
    logic                     r_out_stepped;
    logic                     r_out_busy;

    logic                     advance;
    logic [DELAY_WIDTH-1:0]   elapsed_inc;
    logic                     delay_reached;
    t_pos                     move_mag;
    t_pos                     pos_up;
    t_pos                     pos_base;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_delay     <= HSS_DELAY_RESET;
            r_steps_per_turn <= HSS_SPT_RESET;
        end else if (i_cfg_we) begin
            case (t_reg_index'(i_cfg_index))
                REG_STEP_DELAY:     r_step_delay     <= i_cfg_data;
                REG_STEPS_PER_TURN: r_steps_per_turn <= i_cfg_data[HSS_POS_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    assign advance    = !r_out_vld || i_out_ready;
    assign o_in_ready = !r_in_vld || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_mode <= i_mode;
            r_in_move <= i_move_steps;
        end
    end

    // update logic
    assign elapsed_inc   = (&r_elapsed) ? r_elapsed : r_elapsed + 1'b1;
    // a delay beyond the counter range behaves as the counter maximum
    assign delay_reached = (CMP_WIDTH'(elapsed_inc) >= CMP_WIDTH'(r_step_delay))
                        || (&elapsed_inc);
    assign move_mag      = r_in_move[15] ? t_pos'(16'd0 - r_in_move) : t_pos'(r_in_move);
    assign pos_up        = r_position + 1'b1;
    assign pos_base      = (r_position == '0) ? r_steps_per_turn : r_position;

    always_comb begin
        n_position  = r_position;
        n_remaining = r_remaining;
        n_forward   = r_forward;
        n_elapsed   = r_elapsed;
        n_coil      = r_coil;
        n_stepped   = 1'b0;
        if (r_in_mode == MODE_MOVE) begin
            n_remaining = move_mag;
            if (r_in_move[15]) begin
                n_forward = 1'b0;
            end else if (r_in_move != '0) begin
                n_forward = 1'b1;
            end
        end else begin
            n_elapsed = elapsed_inc;
            if ((r_remaining != '0) && delay_reached) begin
                n_elapsed   = '0;
                n_stepped   = 1'b1;
                n_remaining = r_remaining - 1'b1;
                if (r_forward) begin
                    n_position = (pos_up == r_steps_per_turn) ? '0 : pos_up;
                end else begin
                    n_position = pos_base - 1'b1;
                end
                n_coil = hss_coil_lookup(n_position[2:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position  <= '0;
            r_remaining <= '0;
            r_forward   <= 1'b0;
            r_elapsed   <= '0;
            r_coil      <= '0;
            r_out_vld   <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_in_vld;
            if (r_in_vld) begin
                r_position  <= n_position;
                r_remaining <= n_remaining;
                r_forward   <= n_forward;
                r_elapsed   <= n_elapsed;
                r_coil      <= n_coil;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (advance && r_in_vld) begin
            r_out_coil      <= n_coil;
            r_out_position  <= n_position;
            r_out_remaining <= n_remaining;
            r_out_stepped   <= n_stepped;
            r_out_busy      <= (n_remaining != '0);
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_coil_pattern = r_out_coil;
    assign o_position     = r_out_position;
    assign o_remaining    = r_out_remaining;
    assign o_stepped      = r_out_stepped;
    assign o_busy_res     = r_out_busy;

endmodule

@@ src/hss_checker.sv @@
// ----------------------------------------------------------------------------
// hss_checker
// port-level checks for the half-step stepper sequencer, bound to the top
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "half_step_stepper_sequencer_unit_defines.svh"

module hss_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [3:0]  o_coil_pattern,
    input logic [15:0] o_position,
    input logic [15:0] o_remaining
);

    `HSS_ASSERT(a_out_valid_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid)
    `HSS_ASSERT(a_out_payload_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> $stable(o_position) && $stable(o_remaining) && $stable(o_coil_pattern))
    `HSS_ASSERT_ALWAYS(a_reset_clears_out, i_clk, $past(!i_rst_n) |-> !o_out_valid)
    // input side only stalls while a result is waiting
    `HSS_ASSERT(a_stall_needs_result, i_clk, i_rst_n, !o_in_ready |-> o_out_valid)

endmodule

bind half_step_stepper_sequencer_unit hss_checker u_hss_checker (.*);
